[hw/rtl/arpgw_pkg.sv]
// Package for the ARP gateway responder: header offsets, protocol constants,
// payload and queue command types, and the reply byte rewrite function.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package arpgw_pkg;

  localparam int HDR_LEN = 42;
  localparam int POS_W = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [POS_W-1:0] pos_t;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] HTYPE_ETH = 16'h0001;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY = 16'h0002;

  localparam pos_t OFF_ETYPE = 6'd12;
  localparam pos_t OFF_HTYPE = 6'd14;
  localparam pos_t OFF_PTYPE = 6'd16;
  localparam pos_t OFF_OPER = 6'd20;
  localparam pos_t OFF_SHA = 6'd22;
  localparam pos_t OFF_SIP = 6'd28;
  localparam pos_t OFF_THA = 6'd32;
  localparam pos_t OFF_TIP = 6'd38;
  localparam pos_t OFF_LAST = 6'd41;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       is_reply;
  } frame_out_t;

  typedef enum logic [0:0] {
    CFG_GATEWAY_IP  = 1'b0,
    CFG_GATEWAY_MAC = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    CMD_PASS   = 1'b0,
    CMD_REPLAY = 1'b1
  } cmd_kind_t;

  // A pass command carries one trailing byte; a replay command tells the
  // back end to play out the first count bytes of the header memory.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    pos_t       count;
    logic       reply;
  } cmd_t;

  typedef struct packed {
    logic       en;
    pos_t       addr;
    logic [7:0] data;
  } mem_wr_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] v, input pos_t k);
    logic [7:0] r;
    case (k)
      6'd0: r = v[47:40];
      6'd1: r = v[39:32];
      6'd2: r = v[31:24];
      6'd3: r = v[23:16];
      6'd4: r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] v, input pos_t k);
    logic [7:0] r;
    case (k)
      6'd0: r = v[31:24];
      6'd1: r = v[23:16];
      6'd2: r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  // Byte idx of the reply header, built from the stored request byte and the
  // requester and gateway addresses.
  function automatic logic [7:0] reply_byte(input pos_t idx, input logic [7:0] raw,
                                            input logic [47:0] sha, input logic [31:0] sip,
                                            input logic [47:0] mac, input logic [31:0] ip);
    logic [7:0] r;
    case (idx) inside
      [6'd0:6'd5]:   r = mac_byte(sha, idx);
      [6'd6:6'd11]:  r = mac_byte(mac, pos_t'(idx - 6'd6));
      OFF_OPER:      r = OP_REPLY[15:8];
      6'd21:         r = OP_REPLY[7:0];
      [6'd22:6'd27]: r = mac_byte(mac, pos_t'(idx - OFF_SHA));
      [6'd28:6'd31]: r = ip_byte(ip, pos_t'(idx - OFF_SIP));
      [6'd32:6'd37]: r = mac_byte(sha, pos_t'(idx - OFF_THA));
      [6'd38:6'd41]: r = ip_byte(sip, pos_t'(idx - OFF_TIP));
      default:       r = raw;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/arpgw_front.sv]
// Front end of the ARP gateway responder: accepts frame bytes, writes the
// header into the back end's memory, qualifies the request and queues commands.
// Depends on arpgw_pkg.
`timescale 1ns / 1ps

module arpgw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  arpgw_pkg::frame_in_t req,
  input  logic [31:0]         gateway_ip,
  input  logic                q_ready,
  output logic                q_push,
  output arpgw_pkg::cmd_t     q_cmd,
  output arpgw_pkg::mem_wr_t  mem_wr,
  output logic [47:0]         sha,
  output logic [31:0]         sip,
  input  logic                replay_done
);
  import arpgw_pkg::*;

  pos_t        pos;
  logic        ok;
  logic        reply_flag;
  logic        hdr_busy;
  logic [23:0] tip;

  logic in_hdr;
  logic last_hdr;
  logic acc;
  logic b_ok;
  logic qualify;

  function automatic logic byte_ok(input pos_t p, input logic [7:0] b);
    logic r;
    case (p)
      OFF_ETYPE:  r = (b == ETYPE_ARP[15:8]);
      6'd13:      r = (b == ETYPE_ARP[7:0]);
      OFF_HTYPE:  r = (b == HTYPE_ETH[15:8]);
      6'd15:      r = (b == HTYPE_ETH[7:0]);
      OFF_PTYPE:  r = (b == ETYPE_IPV4[15:8]);
      6'd17:      r = (b == ETYPE_IPV4[7:0]);
      OFF_OPER:   r = (b == OP_REQUEST[15:8]);
      6'd21:      r = (b == OP_REQUEST[7:0]);
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

  always_comb begin
    in_hdr = (pos < pos_t'(HDR_LEN));
    last_hdr = (pos == OFF_LAST);
    // Header bytes wait while the previous header is still being replayed.
    req_ready = q_ready && (!in_hdr || !hdr_busy);
    acc = req_valid && req_ready;
    b_ok = byte_ok(pos, req.frame_byte);
    qualify = ok && b_ok && ({tip, req.frame_byte} == gateway_ip);

    q_push = acc && (!in_hdr || last_hdr || req.frame_end);
    q_cmd.data = req.frame_byte;
    q_cmd.count = pos_t'(pos + 6'd1);
    if (!in_hdr) begin
      q_cmd.kind = CMD_PASS;
      q_cmd.last = req.frame_end;
      q_cmd.reply = reply_flag;
    end else if (last_hdr) begin
      q_cmd.kind = CMD_REPLAY;
      q_cmd.last = req.frame_end;
      q_cmd.reply = qualify;
    end else begin
      q_cmd.kind = CMD_REPLAY;
      q_cmd.last = 1'b1;
      q_cmd.reply = 1'b0;
    end

    mem_wr.en = acc && in_hdr;
    mem_wr.addr = pos;
    mem_wr.data = req.frame_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ok <= 1'b0;
      reply_flag <= 1'b0;
      hdr_busy <= 1'b0;
    end else begin
      if (acc) begin
        if (req.frame_end) begin
          pos <= '0;
          reply_flag <= 1'b0;
        end else begin
          if (in_hdr) begin
            pos <= pos_t'(pos + 6'd1);
          end
          if (last_hdr) begin
            reply_flag <= qualify;
          end
        end
        if (in_hdr) begin
          ok <= ((pos == '0) ? 1'b1 : ok) && b_ok;
        end
      end
      if (q_push && q_cmd.kind == CMD_REPLAY) begin
        hdr_busy <= 1'b1;
      end else if (replay_done) begin
        hdr_busy <= 1'b0;
      end
    end
  end

  // Requester addresses and the target IP are collected as they stream by.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (pos >= OFF_SHA && pos < OFF_SIP) begin
        sha <= {sha[39:0], req.frame_byte};
      end
      if (pos >= OFF_SIP && pos < OFF_THA) begin
        sip <= {sip[23:0], req.frame_byte};
      end
      if (pos >= OFF_TIP && pos < OFF_LAST) begin
        tip <= {tip[15:0], req.frame_byte};
      end
    end
  end

endmodule

[hw/rtl/arpgw_queue.sv]
// Short command queue between the front and back ends of the ARP responder.
// Depends on arpgw_pkg.
`timescale 1ns / 1ps

module arpgw_queue #(
  parameter int DEPTH = arpgw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  arpgw_pkg::cmd_t wr,
  output logic            ready,
  input  logic            pop,
  output arpgw_pkg::cmd_t rd,
  output logic            valid
);
  import arpgw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    ready = (count != CNT_W'(DEPTH));
    valid = (count != '0);
    rd = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr;
    end
  end

endmodule

[hw/rtl/arpgw_back.sv]
// Back end of the ARP responder: holds the header memory, replays it with the
// reply rewrite applied, passes trailing bytes, and drives the output register.
// Depends on arpgw_pkg.
`timescale 1ns / 1ps

module arpgw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  arpgw_pkg::cmd_t      q_cmd,
  input  arpgw_pkg::mem_wr_t   mem_wr,
  input  logic [47:0]          sha,
  input  logic [31:0]          sip,
  input  logic [31:0]          gateway_ip,
  input  logic [47:0]          gateway_mac,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output arpgw_pkg::frame_out_t rsp,
  output logic                 replay_done
);
  import arpgw_pkg::*;

  logic [7:0] mem [HDR_LEN];
  logic [7:0] mem_q;

  logic       rp_active;
  pos_t       rp_idx;
  pos_t       rp_cnt;
  logic       rp_end;
  logic       rp_reply;
  logic       rd_pend;
  pos_t       rd_idx;
  logic       rd_last;
  logic       out_valid;
  frame_out_t out_q;

  logic       free;
  logic       issue_rp;
  logic       start_rp;
  logic       issue;
  logic       issue_last;
  pos_t       rd_addr;
  logic [7:0] rd_byte;

  always_comb begin
    // The output register is free now or is emptied at this edge; a read
    // issued now passes through mem_q before it lands there.
    free = !out_valid || rsp_ready;
    issue_rp = rp_active && !rd_pend && free;
    q_pop = !rp_active && !rd_pend && free && q_valid;
    start_rp = q_pop && (q_cmd.kind == CMD_REPLAY);
    issue = issue_rp || start_rp;
    rd_addr = start_rp ? '0 : rp_idx;
    issue_last = start_rp ? (q_cmd.count == pos_t'(1)) : (rp_idx == pos_t'(rp_cnt - 6'd1));
    rd_byte = rp_reply ? reply_byte(rd_idx, mem_q, sha, sip, gateway_mac, gateway_ip)
                       : mem_q;
    replay_done = rd_pend && rd_last;
    rsp_valid = out_valid;
    rsp = out_q;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (issue) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp_active <= 1'b0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (start_rp) begin
        rp_active <= (q_cmd.count != pos_t'(1));
      end else if (issue_rp && issue_last) begin
        rp_active <= 1'b0;
      end
      if (rd_pend || (q_pop && q_cmd.kind == CMD_PASS)) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_rp) begin
      rp_cnt <= q_cmd.count;
      rp_end <= q_cmd.last;
      rp_reply <= q_cmd.reply;
      rp_idx <= pos_t'(1);
    end else if (issue_rp) begin
      rp_idx <= pos_t'(rp_idx + 6'd1);
    end
    if (issue) begin
      rd_idx <= rd_addr;
      rd_last <= issue_last;
    end
    if (rd_pend) begin
      out_q.out_byte <= rd_byte;
      out_q.out_end <= rd_last && rp_end;
      out_q.is_reply <= rp_reply;
    end else if (q_pop && q_cmd.kind == CMD_PASS) begin
      out_q.out_byte <= q_cmd.data;
      out_q.out_end <= q_cmd.last;
      out_q.is_reply <= q_cmd.reply;
    end
  end

  a_read_lands_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("header read returned while the output register was occupied");

  a_done_ends_replay: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && rd_last) |-> !rp_active)
    else $error("replay still active after its last read");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    rp_active |-> (rp_idx < rp_cnt))
    else $error("replay index ran past the byte count");

endmodule

[hw/rtl/arp_gateway_responder_core.sv]
// Top level of the ARP gateway responder: configuration registers and the
// front end, command queue and back end. Depends on arpgw_pkg and submodules.
`timescale 1ns / 1ps

// Frame bytes enter on req and leave on rsp. A frame whose first 42 bytes form
// an Ethernet/IPv4 ARP request for the configured gateway IP comes back as an
// ARP reply with is_reply set; anything else leaves unchanged. No byte is
// returned until the 42nd header byte (or an earlier frame end) has arrived;
// the held header is then replayed from the registered header memory (memory
// read, then output register; a read waits until the previous one returned).
// Header bytes of the next frame are taken only after that replay has
// finished. Bytes past the header pass through at one per cycle while rsp_ready
// is high and no replay runs. Configuration writes are always taken and should
// be made while no frame is in flight.
module arp_gateway_responder_core #(
  parameter int QUEUE_DEPTH = arpgw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  arpgw_pkg::frame_in_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output arpgw_pkg::frame_out_t rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  arpgw_pkg::cfg_idx_t   cfg_index,
  input  logic [47:0]           cfg_data
);
  import arpgw_pkg::*;

  logic [31:0] gateway_ip;
  logic [47:0] gateway_mac;

  logic        q_ready;
  logic        q_push;
  cmd_t        q_wr;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_rd;
  mem_wr_t     mem_wr;
  logic [47:0] sha;
  logic [31:0] sip;
  logic        replay_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gateway_ip <= '0;
      gateway_mac <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GATEWAY_IP:  gateway_ip <= cfg_data[31:0];
        CFG_GATEWAY_MAC: gateway_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  arpgw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .gateway_ip  (gateway_ip),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (q_wr),
    .mem_wr      (mem_wr),
    .sha         (sha),
    .sip         (sip),
    .replay_done (replay_done)
  );

  arpgw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wr    (q_wr),
    .ready (q_ready),
    .pop   (q_pop),
    .rd    (q_rd),
    .valid (q_valid)
  );

  arpgw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_rd),
    .mem_wr      (mem_wr),
    .sha         (sha),
    .sip         (sip),
    .gateway_ip  (gateway_ip),
    .gateway_mac (gateway_mac),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .replay_done (replay_done)
  );

endmodule
